### hdl/etc_pkg.sv
// Shared types, register offsets and codes for the event timer block.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
package etc_pkg;

	localparam int Comparators = 3;
	localparam int StatusW     = 3;
	localparam int RouteW      = 5;
	localparam int SettingsW   = 2 + RouteW;
	localparam int CfgIdxW     = 1;
	localparam int CfgDataW    = 32;
	localparam int PeriodW     = 27;
	localparam int AddrW       = 11;

	localparam logic [AddrW-1:0] OFF_CAP       = 11'h000;
	localparam logic [AddrW-1:0] OFF_GEN_CFG   = 11'h010;
	localparam logic [AddrW-1:0] OFF_STATUS    = 11'h020;
	localparam logic [AddrW-1:0] OFF_COUNTER   = 11'h0F0;
	localparam logic [AddrW-1:0] OFF_COMP_BASE = 11'h100;

	// comparator blocks are 0x20 apart: block number is address bits 10:5
	localparam logic [5:0] CompBlk = 6'(OFF_COMP_BASE >> 5);

	// word select inside a comparator block, address bits 4:3
	localparam logic [1:0] COMP_WORD_CFG = 2'd0;
	localparam logic [1:0] COMP_WORD_VAL = 2'd1;

	localparam logic [7:0]  CapRevision   = 8'h01;
	localparam logic [31:0] TickPeriodRst = 32'd10000000;
	localparam logic [31:0] RouteCapRst   = 32'd15728640;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TICK_PERIOD = 1'b0,
		CFG_ROUTE_CAP   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [AddrW-1:0] address;
		logic [63:0]      write_data;
	} item_t;

	typedef struct packed {
		logic [63:0]        read_data;
		logic [StatusW-1:0] interrupt_status;
		logic [31:0]        irq_lines;
	} result_t;

	// core to comparator bank
	typedef struct packed {
		logic             wr;
		logic [AddrW-1:0] addr;
		logic [63:0]      wdata;
		logic [63:0]      counter_next;
	} cmp_req_t;

	// comparator bank to core
	typedef struct packed {
		logic [63:0]            rd_word;
		logic [31:0]            lines;
	} cmp_rsp_t;

endpackage

### hdl/etc_if.sv
// Valid/ready channel interfaces for timer items and timer results.
// Depends on etc_pkg for field widths.
interface etc_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                operation;
	logic [etc_pkg::AddrW-1:0] address;
	logic [63:0]               write_data;

	modport source (output valid, operation, address, write_data, input ready);
	modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface etc_out_if;
	logic                        valid;
	logic                        ready;
	logic [63:0]                 read_data;
	logic [etc_pkg::StatusW-1:0] interrupt_status;
	logic [31:0]                 irq_lines;

	modport source (output valid, read_data, interrupt_status, irq_lines, input ready);
	modport sink   (input valid, read_data, interrupt_status, irq_lines, output ready);
endinterface

### hdl/etc_cmp_bank.sv
// Comparator bank: per-comparator settings and compare words, match and line logic.
// Depends on etc_pkg.
module etc_cmp_bank (
	input  logic                              clk,
	input  logic                              arst_n,
	input  etc_pkg::cmp_req_t                 req,
	input  logic [31:0]                       route_cap,
	input  logic [etc_pkg::Comparators-1:0]   pending_next,
	input  logic                              enable_next,
	output logic [etc_pkg::Comparators-1:0]   match,
	output etc_pkg::cmp_rsp_t                 rsp
);

	logic [etc_pkg::SettingsW-1:0] settings_q [etc_pkg::Comparators];
	logic [etc_pkg::SettingsW-1:0] settings_d [etc_pkg::Comparators];
	logic [63:0]                   value_q    [etc_pkg::Comparators];
	logic [etc_pkg::Comparators-1:0] blk_sel;
	logic [etc_pkg::Comparators-1:0] cfg_wr;
	logic [etc_pkg::Comparators-1:0] val_wr;
	logic [etc_pkg::SettingsW-1:0]   settings_new;

	assign settings_new = {req.wdata[13:9], req.wdata[2], req.wdata[1]};

	for (genvar n = 0; n < etc_pkg::Comparators; n++) begin : g_cmp
		assign blk_sel[n] = (req.addr[10:5] == 6'(int'(etc_pkg::CompBlk) + n));
		assign cfg_wr[n]  = req.wr && blk_sel[n] && (req.addr[4:3] == etc_pkg::COMP_WORD_CFG);
		assign val_wr[n]  = req.wr && blk_sel[n] && (req.addr[4:3] == etc_pkg::COMP_WORD_VAL);
		assign settings_d[n] = cfg_wr[n] ? settings_new : settings_q[n];
		assign match[n]      = settings_q[n][1] && (value_q[n] == req.counter_next);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				settings_q[n] <= '0;
				value_q[n]    <= '1;
			end else begin
				settings_q[n] <= settings_d[n];
				if (val_wr[n]) begin
					value_q[n] <= req.wdata;
				end
			end
		end
	end

	always_comb begin
		logic [etc_pkg::RouteW-1:0] route;
		rsp.rd_word = '0;
		rsp.lines   = '0;
		for (int n = 0; n < etc_pkg::Comparators; n++) begin
			if (blk_sel[n]) begin
				case (req.addr[4:3])
					etc_pkg::COMP_WORD_CFG: rsp.rd_word = {route_cap, 18'b0,
						settings_q[n][6:2], 3'b0, 1'b1, 2'b0,
						settings_q[n][1], settings_q[n][0], 1'b0};
					etc_pkg::COMP_WORD_VAL: rsp.rd_word = value_q[n];
					default:                rsp.rd_word = '0;
				endcase
			end
			// drive the routed line only if the capability mask allows it
			route = settings_d[n][6:2];
			if (enable_next && pending_next[n] && settings_d[n][1] && route_cap[route]) begin
				rsp.lines[route] = 1'b1;
			end
		end
	end

endmodule

### hdl/etc_core.sv
// Timer core: main counter, enable, pending bits, configuration registers.
// Depends on etc_pkg and etc_cmp_bank.
module etc_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [etc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [etc_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                            step,
	input  etc_pkg::item_t                  item,
	output etc_pkg::result_t                result
);

	logic [etc_pkg::PeriodW-1:0]     period_q;
	logic [31:0]                     route_cap_q;
	logic [63:0]                     counter_q;
	logic [63:0]                     counter_d;
	logic [63:0]                     counter_inc;
	logic                            enable_q;
	logic                            enable_d;
	logic [etc_pkg::Comparators-1:0] pending_q;
	logic [etc_pkg::Comparators-1:0] pending_d;
	logic [etc_pkg::AddrW-1:0]       addr;
	logic                            do_tick;
	logic                            do_read;
	logic                            do_write;
	logic [etc_pkg::StatusW+etc_pkg::Comparators-1:0] status_ext;
	logic [etc_pkg::Comparators-1:0] cmp_match;
	etc_pkg::cmp_req_t               cmp_req;
	etc_pkg::cmp_rsp_t               cmp_rsp;

	assign addr        = {item.address[etc_pkg::AddrW-1:3], 3'b000};
	assign do_tick     = step && (item.op == etc_pkg::OP_TICK) && enable_q;
	assign do_read     = (item.op == etc_pkg::OP_READ);
	assign do_write    = step && (item.op == etc_pkg::OP_WRITE);
	assign counter_inc = counter_q + 64'd1;

	assign cmp_req.wr           = do_write;
	assign cmp_req.addr         = addr;
	assign cmp_req.wdata        = item.write_data;
	assign cmp_req.counter_next = counter_inc;

	etc_cmp_bank u_cmp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (cmp_req),
		.route_cap    (route_cap_q),
		.pending_next (pending_d),
		.enable_next  (enable_d),
		.match        (cmp_match),
		.rsp          (cmp_rsp)
	);

	always_comb begin
		counter_d = counter_q;
		enable_d  = enable_q;
		pending_d = pending_q;
		if (do_tick) begin
			counter_d = counter_inc;
			pending_d = pending_q | cmp_match;
		end
		if (do_write) begin
			case (addr)
				etc_pkg::OFF_GEN_CFG: enable_d  = item.write_data[0];
				etc_pkg::OFF_STATUS:  pending_d = pending_q &
					~item.write_data[etc_pkg::Comparators-1:0];
				etc_pkg::OFF_COUNTER: counter_d = item.write_data;
				default:              ;
			endcase
		end
	end

	always_comb begin
		result.read_data = '0;
		if (do_read) begin
			case (addr)
				etc_pkg::OFF_CAP:     result.read_data = {5'b0, period_q, 18'b0, 1'b1,
					5'(etc_pkg::Comparators - 1), etc_pkg::CapRevision};
				etc_pkg::OFF_GEN_CFG: result.read_data = {63'b0, enable_q};
				etc_pkg::OFF_STATUS:  result.read_data = 64'(pending_q);
				etc_pkg::OFF_COUNTER: result.read_data = counter_q;
				default:              result.read_data = cmp_rsp.rd_word;
			endcase
		end
	end

	assign status_ext              = {etc_pkg::StatusW'(0), pending_d};
	assign result.interrupt_status = status_ext[etc_pkg::StatusW-1:0];
	assign result.irq_lines        = cmp_rsp.lines;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			enable_q  <= 1'b0;
			pending_q <= '0;
		end else if (step) begin
			counter_q <= counter_d;
			enable_q  <= enable_d;
			pending_q <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= etc_pkg::PeriodW'(etc_pkg::TickPeriodRst);
			route_cap_q <= etc_pkg::RouteCapRst;
		end else if (cfg_we) begin
			case (etc_pkg::cfg_idx_t'(cfg_index))
				etc_pkg::CFG_TICK_PERIOD: period_q    <= cfg_data[etc_pkg::PeriodW-1:0];
				etc_pkg::CFG_ROUTE_CAP:   route_cap_q <= cfg_data;
				default:                  ;
			endcase
		end
	end

endmodule

### hdl/event_timer_comparators_unit.sv
// Event timer with a 64-bit main counter and a bank of match comparators.
// A transferred item waits in the item register until the result register is
// empty or being emptied; the core's result for it then loads the result register.
// Throughput: one item per cycle while results are taken, set by the combinational
// core pass (counter increment, parallel 64-bit compares) between those registers.
// Reset (arst_n low, asynchronous): pipeline empty, counter, enable and status
// cleared, compare words all ones, configuration registers at their defaults.
module event_timer_comparators_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [etc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [etc_pkg::CfgDataW-1:0]  cfg_data,
	etc_in_if.sink                        item_ch,
	etc_out_if.source                     result_ch
);

	// item register: holds the transferred item while the core works on it
	logic             valid_s1;
	etc_pkg::item_t   item_s1;
	// result register: holds the finished result until it is taken
	logic             valid_s2;
	etc_pkg::result_t result_s2;

	etc_pkg::result_t core_result;
	logic             adv_s2;
	logic             step;

	// The result register may load when it is empty or its contents leave
	// in this cycle; the core commits its state update only on that edge, so
	// every item updates the state exactly once.
	assign adv_s2        = !valid_s2 || result_ch.ready;
	assign step          = valid_s1 && adv_s2;
	assign item_ch.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ch.ready) begin
			valid_s1 <= item_ch.valid;
		end
	end

	// capture the payload on a transfer; hold it otherwise
	always_ff @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			item_s1.op         <= etc_pkg::op_t'(item_ch.operation);
			item_s1.address    <= item_ch.address;
			item_s1.write_data <= item_ch.write_data;
		end
	end

	etc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.item      (item_s1),
		.result    (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// load a fresh result only when the core commits the item behind it
	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= core_result;
		end
	end

	assign result_ch.valid            = valid_s2;
	assign result_ch.read_data        = result_s2.read_data;
	assign result_ch.interrupt_status = result_s2.interrupt_status;
	assign result_ch.irq_lines        = result_s2.irq_lines;

endmodule

### hdl/etc_checker.sv
// Port-level checks for the event timer; attached to the top level by bind.
// Depends on event_timer_comparators_unit and etc_pkg.
module etc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [63:0]                 read_data,
	input logic [etc_pkg::StatusW-1:0] interrupt_status,
	input logic [31:0]                 irq_lines
);

	// a transferred item has a result on offer once it is through the item and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |-> ##2 result_valid)
		else $error("no result two cycles after an item transfer");

	// with no result waiting the block must take a new item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item side stalled with an empty result register");

	// an interrupt line is only driven by a pending comparator
	a_lines_need_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (irq_lines == 32'd0 || interrupt_status != '0))
		else $error("interrupt line driven with no status bit pending");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(read_data)
			&& $stable(interrupt_status) && $stable(irq_lines))
		else $error("stalled result changed");

endmodule

bind event_timer_comparators_unit etc_checker u_etc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item_ch.valid),
	.item_ready       (item_ch.ready),
	.result_valid     (result_ch.valid),
	.result_ready     (result_ch.ready),
	.read_data        (result_ch.read_data),
	.interrupt_status (result_ch.interrupt_status),
	.irq_lines        (result_ch.irq_lines)
);

### tb/etc_outcome_checker.sv
// Result checker for the event timer: mirrors timer state from observed
// transfers and configuration writes, and compares every result in order.
// Depends on etc_pkg and the etc_in_if / etc_out_if channel interfaces.
module etc_outcome_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [etc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [etc_pkg::CfgDataW-1:0] cfg_data,
	etc_in_if                            item_ch,
	etc_out_if                           result_ch,
	output int unsigned                  outcomes_due,
	output int unsigned                  failures
);
	import etc_pkg::*;

	// mirrored timer state
	logic [63:0]        count_q;
	logic               run_q;
	logic [StatusW-1:0] pend_q;
	logic [63:0]        match_val [Comparators];
	logic               cmp_level [Comparators];
	logic               cmp_irq_en [Comparators];
	logic [RouteW-1:0]  cmp_route [Comparators];
	logic [PeriodW-1:0] period_q;
	logic [31:0]        route_cap_q;

	result_t outcomes_q[$];

	// apply one item to the mirrored state and return the result it yields
	function automatic result_t timer_outcome(op_t op, logic [AddrW-1:0] address,
			logic [63:0] wdata);
		result_t          res;
		logic [AddrW-1:0] a;
		logic [1:0]       word;
		int               n;
		a = address & 11'h7F8;
		word = a[4:3];
		n = int'(a[10:5]) - int'(CompBlk);
		res = '0;
		case (op)
		OP_TICK: begin
			if (run_q) begin
				count_q = count_q + 64'd1;
				for (int i = 0; i < Comparators; i++)
					if (cmp_irq_en[i] && match_val[i] == count_q)
						pend_q[i] = 1'b1;
			end
		end
		OP_READ: begin
			if (a == OFF_CAP)
				res.read_data = {5'd0, period_q, 18'd0, 1'b1, 5'(Comparators - 1),
					CapRevision};
			else if (a == OFF_GEN_CFG)
				res.read_data = {63'd0, run_q};
			else if (a == OFF_STATUS)
				res.read_data = 64'(pend_q);
			else if (a == OFF_COUNTER)
				res.read_data = count_q;
			else if (n >= 0 && n < Comparators) begin
				if (word == COMP_WORD_CFG)
					res.read_data = {route_cap_q, 18'd0, cmp_route[n], 3'd0, 1'b1, 2'd0,
						cmp_irq_en[n], cmp_level[n], 1'b0};
				else if (word == COMP_WORD_VAL)
					res.read_data = match_val[n];
			end
		end
		OP_WRITE: begin
			if (a == OFF_GEN_CFG)
				run_q = wdata[0];
			else if (a == OFF_STATUS)
				pend_q = pend_q & ~wdata[StatusW-1:0];
			else if (a == OFF_COUNTER)
				count_q = wdata;
			else if (n >= 0 && n < Comparators) begin
				if (word == COMP_WORD_CFG) begin
					cmp_level[n] = wdata[1];
					cmp_irq_en[n] = wdata[2];
					cmp_route[n] = wdata[13:9];
				end else if (word == COMP_WORD_VAL)
					match_val[n] = wdata;
			end
		end
		default: ;
		endcase
		res.interrupt_status = pend_q;
		if (run_q)
			for (int i = 0; i < Comparators; i++)
				if (pend_q[i] && cmp_irq_en[i])
					res.irq_lines |= (32'd1 << cmp_route[i]) & route_cap_q;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t     want;
		int unsigned errs;
		errs = 0;
		if (!arst_n) begin
			count_q = '0;
			run_q = 1'b0;
			pend_q = '0;
			for (int i = 0; i < Comparators; i++) begin
				match_val[i] = '1;
				cmp_level[i] = 1'b0;
				cmp_irq_en[i] = 1'b0;
				cmp_route[i] = '0;
			end
			period_q = TickPeriodRst[PeriodW-1:0];
			route_cap_q = RouteCapRst;
			outcomes_q.delete();
			outcomes_due <= 0;
			failures <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (outcomes_q.size() == 0) begin
					$error("result with nothing awaited: read_data %h status %h lines %h",
						result_ch.read_data, result_ch.interrupt_status, result_ch.irq_lines);
					errs++;
				end else begin
					want = outcomes_q.pop_front();
					if (result_ch.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h",
							want.read_data, result_ch.read_data);
						errs++;
					end
					if (result_ch.interrupt_status !== want.interrupt_status) begin
						$error("interrupt_status: expected %h, got %h",
							want.interrupt_status, result_ch.interrupt_status);
						errs++;
					end
					if (result_ch.irq_lines !== want.irq_lines) begin
						$error("irq_lines: expected %h, got %h",
							want.irq_lines, result_ch.irq_lines);
						errs++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready)
				outcomes_q.push_back(timer_outcome(op_t'(item_ch.operation),
					item_ch.address, item_ch.write_data));
			if (cfg_we) begin
				if (cfg_index == CFG_TICK_PERIOD)
					period_q = cfg_data[PeriodW-1:0];
				else
					route_cap_q = cfg_data;
			end
			outcomes_due <= outcomes_q.size();
			failures <= failures + errs;
		end
	end

endmodule

### tb/tb_event_timer_comparators_unit.sv
// Top of the event timer testbench: clock, reset, stimulus and verdict.
// Depends on etc_pkg, the channel interfaces, the timer block and etc_outcome_checker.
module tb_event_timer_comparators_unit;
	import etc_pkg::*;

	localparam int CycleLimit = 400000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int unsigned outcomes_due;
	int unsigned fail_total;
	int unsigned cycles;
	int unsigned sent;
	// when set, neither side inserts idle cycles
	bit          calm_mode;

	etc_in_if  item_ch ();
	etc_out_if result_ch ();

	event_timer_comparators_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_ch   (item_ch),
		.result_ch (result_ch)
	);

	etc_outcome_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_ch      (item_ch),
		.result_ch    (result_ch),
		.outcomes_due (outcomes_due),
		.failures     (fail_total)
	);

	always #2 clk = ~clk;

	// watchdog: give up well beyond the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("tb_event_timer_comparators_unit: FAIL");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then a long stretch
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// address inside comparator block n, with random ignored low bits
	function automatic logic [AddrW-1:0] comp_addr(int n, logic [1:0] word);
		return OFF_COMP_BASE + AddrW'(n * 32 + int'(word) * 8 + $urandom_range(0, 7));
	endfunction

	// offer one item and hold it until the transfer; valid is only lowered
	// when a gap is wanted, so back-to-back items keep it high
	task automatic send_item(op_t op, logic [AddrW-1:0] address, logic [63:0] data);
		int gap;
		gap = calm_mode ? 0 : idle_len();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.address <= address;
		item_ch.write_data <= data;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
	endtask

	// drop valid and hold off until every awaited result has arrived
	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outcomes_due != 0);
	endtask

	// write both configuration registers on consecutive edges
	task automatic set_config(logic [CfgDataW-1:0] period, logic [CfgDataW-1:0] route_cap);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TICK_PERIOD;
		cfg_data <= period;
		@(posedge clk);
		cfg_index <= CFG_ROUTE_CAP;
		cfg_data <= route_cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Arm one comparator a few ticks ahead of a freshly written counter, then tick
	// to just short of it, onto it or past it, and look at the status. The content
	// is random: the interrupt enable, the route, the counter enable and the tick
	// count all vary, and the counter sometimes starts just below the wrap point.
	task automatic match_sequence();
		int          n;
		int          k;
		logic [63:0] base;
		logic [63:0] word;
		n = $urandom_range(0, Comparators - 1);
		k = $urandom_range(1, 6);
		if ($urandom_range(0, 3) == 0)
			base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4));
		else
			base = {$urandom, $urandom};
		send_item(OP_WRITE, OFF_COUNTER | AddrW'($urandom_range(0, 7)), base);
		send_item(OP_WRITE, comp_addr(n, COMP_WORD_VAL), base + 64'(k));
		word = {$urandom, $urandom};
		word[2] = ($urandom_range(0, 7) != 0);
		send_item(OP_WRITE, comp_addr(n, COMP_WORD_CFG), word);
		word = {$urandom, $urandom};
		word[0] = ($urandom_range(0, 7) != 0);
		send_item(OP_WRITE, OFF_GEN_CFG | AddrW'($urandom_range(0, 7)), word);
		repeat ($urandom_range(k - 1, k + 2))
			send_item(OP_TICK, AddrW'($urandom), {$urandom, $urandom});
		send_item(OP_READ, OFF_STATUS, {$urandom, $urandom});
		if ($urandom_range(0, 1) == 1)
			send_item(OP_WRITE, OFF_STATUS, {$urandom, $urandom});
	endtask

	// mix of armed comparator runs, plain register traffic, tick bursts and
	// noise; a hold-off until the pipe is empty turns up now and then
	task automatic random_phase(int quota);
		int               first;
		int               r;
		logic [AddrW-1:0] a;
		first = sent;
		send_item(OP_READ, OFF_CAP, {$urandom, $urandom});
		while (sent - first < quota) begin
			r = $urandom_range(0, 19);
			if (r < 10)
				match_sequence();
			else if (r < 14) begin
				case ($urandom_range(0, 5))
				0: a = OFF_CAP;
				1: a = OFF_GEN_CFG;
				2: a = OFF_STATUS;
				3: a = OFF_COUNTER;
				default: a = comp_addr($urandom_range(0, Comparators), 2'($urandom_range(0, 3)));
				endcase
				a = a | AddrW'($urandom_range(0, 7));
				send_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, a, {$urandom, $urandom});
			end else if (r < 17)
				repeat ($urandom_range(1, 8))
					send_item(OP_TICK, AddrW'($urandom), {$urandom, $urandom});
			else if (r < 19)
				send_item(op_t'($urandom_range(0, 3)), AddrW'($urandom), {$urandom, $urandom});
			else
				drain();
		end
	endtask

	// result side: accept for a burst, then, unless calm_mode is set, stall for a random while
	initial begin : result_sink
		int n;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			n = calm_mode ? 0 : idle_len();
			if (n > 0) begin
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sent = 0;
		calm_mode = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TICK_PERIOD;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_NOP;
		item_ch.address = '0;
		item_ch.write_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, default configuration: reset values of the global registers
		// and of two comparator words, a tick with the counter stopped, the spare
		// operation code, unmapped offsets (including a comparator past the last one),
		// writes to the read-only capability word, and a counter wrap that fires two
		// comparators at once, one routed inside the capability and one not.
		send_item(OP_READ, OFF_CAP, '0);
		send_item(OP_READ, OFF_GEN_CFG, '0);
		send_item(OP_READ, OFF_STATUS, '0);
		send_item(OP_READ, OFF_COUNTER, '0);
		send_item(OP_READ, OFF_COMP_BASE, '0);
		send_item(OP_READ, OFF_COMP_BASE + 11'h048, '0);
		send_item(OP_TICK, 11'h7FF, '1);
		send_item(OP_NOP, 11'h7FF, '1);
		send_item(OP_READ, 11'h7FF, '1);
		send_item(OP_WRITE, OFF_COMP_BASE + 11'h060, '1);
		send_item(OP_READ, OFF_COMP_BASE + 11'h060, '0);
		send_item(OP_WRITE, OFF_CAP, '1);
		send_item(OP_WRITE, OFF_COMP_BASE, '1);
		send_item(OP_READ, OFF_COMP_BASE | 11'h007, '0);
		send_item(OP_WRITE, OFF_COMP_BASE + 11'h008, '0);
		send_item(OP_WRITE, OFF_COMP_BASE + 11'h020, 64'h4 | (64'd20 << 9));
		send_item(OP_WRITE, OFF_COMP_BASE + 11'h028, '0);
		send_item(OP_WRITE, OFF_COMP_BASE + 11'h040, 64'h4);
		send_item(OP_WRITE, OFF_COMP_BASE + 11'h048, 64'd1);
		send_item(OP_WRITE, OFF_COUNTER | 11'h007, '1);
		send_item(OP_WRITE, OFF_GEN_CFG, 64'h1);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_READ, OFF_COMP_BASE + 11'h018, '0);
		send_item(OP_WRITE, OFF_STATUS, 64'h5);
		send_item(OP_READ, OFF_STATUS, '0);
		send_item(OP_WRITE, OFF_GEN_CFG, '0);
		send_item(OP_READ, OFF_COMP_BASE + 11'h010, '0);
		drain();

		// Random phases, one configuration each, always written with the pipe empty.
		// Extremes first, then an oversized period whose high bits must drop, run
		// without any idling, then random values, then the reset period with a full capability mask.
		set_config(32'd1, 32'hFFFF_FFFF);
		random_phase(80);
		drain();
		set_config(32'd100000000, 32'h0);
		random_phase(80);
		drain();
		calm_mode = 1'b1;
		set_config(32'hFFFF_FFFF, 32'h0000_FFFF);
		random_phase(80);
		drain();
		calm_mode = 1'b0;
		set_config(32'($urandom_range(1, 100000000)), $urandom);
		random_phase(80);
		drain();
		set_config(TickPeriodRst, 32'hFFFF_FFFF);
		random_phase(80);

		// settle: nothing awaited, then an idle stretch before the verdict
		drain();
		repeat (8) @(posedge clk);
		if (fail_total == 0)
			$display("tb_event_timer_comparators_unit: PASS");
		else
			$display("tb_event_timer_comparators_unit: FAIL");
		$finish;
	end

endmodule
